FILE: src/kns_pkg.sv
package kns_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int POS_BITS    = 24;
    localparam int DIR_BITS    = 16;
    localparam int DIST_BITS   = 48;
    localparam int ID_BITS     = 16;
    localparam int SUM_W       = POS_BITS + IDX_W;
    localparam int STEP_W      = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_INSERT   = 2'd1,
        ACT_FINALIZE = 2'd2,
        ACT_UNUSED   = 2'd3
    } action_t;

    typedef struct packed {
        logic [DIST_BITS-1:0]       dist_sq;
        logic [ID_BITS-1:0]         id;
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_z;
        logic signed [DIR_BITS-1:0] dir_x;
        logic signed [DIR_BITS-1:0] dir_z;
    } entry_t;

    typedef struct packed {
        logic take_cand;
        logic take_left;
    } cell_ctrl_t;

endpackage

FILE: src/kns_cand_if.sv
interface kns_cand_if;
    import kns_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [DIST_BITS-1:0]       dist_sq;
    logic [ID_BITS-1:0]         neighbor_id;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_z;
    logic signed [DIR_BITS-1:0] dir_x;
    logic signed [DIR_BITS-1:0] dir_z;

    modport source (output valid, action, dist_sq, neighbor_id, pos_x, pos_z, dir_x, dir_z,
                    input ready);
    modport sink (input valid, action, dist_sq, neighbor_id, pos_x, pos_z, dir_x, dir_z,
                  output ready);
endinterface

FILE: src/kns_report_if.sv
interface kns_report_if;
    import kns_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CNT_W-1:0]           entry_count;
    logic                       accepted;
    logic signed [POS_BITS-1:0] centroid_x;
    logic signed [POS_BITS-1:0] centroid_z;
    logic signed [DIR_BITS-1:0] mean_dir_x;
    logic signed [DIR_BITS-1:0] mean_dir_z;

    modport source (output valid, entry_count, accepted, centroid_x, centroid_z,
                    mean_dir_x, mean_dir_z, input ready);
    modport sink (input valid, entry_count, accepted, centroid_x, centroid_z,
                  mean_dir_x, mean_dir_z, output ready);
endinterface

FILE: src/kns_cell.sv
module kns_cell
    import kns_pkg::*;
(
    input  logic       clk,
    input  entry_t     cand,
    input  entry_t     left,
    input  cell_ctrl_t ctrl,
    output entry_t     entry,
    output logic       ranks_before
);

    entry_t entry_reg;

    // The candidate sorts ahead of this entry on distance, then on smaller id.
    assign ranks_before = (entry_reg.dist_sq > cand.dist_sq) ||
                          ((entry_reg.dist_sq == cand.dist_sq) && (entry_reg.id > cand.id));
    assign entry = entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.take_cand)
        begin
            entry_reg <= cand;
        end
        else if (ctrl.take_left)
        begin
            entry_reg <= left;
        end
    end

endmodule

FILE: src/kns_div.sv
module kns_div
    import kns_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] sum,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]  q_reg, q_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic              neg_reg, neg_next;
    logic [CNT_W:0]    rem_sh;
    logic              ge;

    // Restoring division of the magnitude, one quotient bit per cycle.
    always_comb
    begin
        rem_sh    = {rem_reg[CNT_W-1:0], q_reg[SUM_W-1]};
        ge        = rem_sh >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            neg_next  = sum[SUM_W-1];
            q_next    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            q_next    = {q_reg[SUM_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

FILE: src/k_nearest_sorted_neighbor_list_core.sv
// Sorted list of the nearest candidates, kept in a row of cells.
// Channels: "cand" carries one word per item (clear, insert, finalize); "report"
// returns exactly one word per item with the entry count, the insert flag and
// the stored means. cfg_we/cfg_wdata write the list capacity; the user must
// write it only while idle, as the block does not enforce it. A clear or insert
// word is accepted every cycle while the output is free, and its report word
// appears in the output register on the next edge. Every cell compares the
// candidate against its own entry in parallel; the cells past the insert point
// take their left neighbor's entry in the same cycle. A finalize word with a
// non-empty list walks the cells one per cycle to sum them; four bit-serial
// dividers then run in parallel, their quotients are stored as the means, and
// the report register is loaded last. No new word is taken meanwhile.
// With an empty list, finalize is answered directly from idle, like a clear.
// Reset empties the list, clears the stored means and sets capacity to 16.
// Entries themselves are not cleared; only entries below the count are read.
// When the receiver stalls, the report register holds its word; one more input
// word may be accepted only in the cycle the held word is taken.
module k_nearest_sorted_neighbor_list_core
    import kns_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    kns_cand_if.sink         cand,
    kns_report_if.source     report
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]           cap_reg;
    logic [CNT_W-1:0]           held_reg, held_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic signed [SUM_W-1:0]    acc_reg [4];
    logic signed [SUM_W-1:0]    acc_next [4];
    logic signed [POS_BITS-1:0] cx_reg, cx_next, cz_reg, cz_next;
    logic signed [DIR_BITS-1:0] dx_reg, dx_next, dz_reg, dz_next;

    logic                       out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]           out_cnt_reg, out_cnt_next;
    logic                       out_acc_reg, out_acc_next;

    entry_t                     cand_entry;
    entry_t                     cells [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]     rb;
    logic [MAX_ENTRIES-1:0]     eff_rb;
    cell_ctrl_t                 ctrl [MAX_ENTRIES];
    logic [CNT_W-1:0]           cap_eff;
    logic                       full;
    logic                       ins_ok;
    logic                       ins_go;
    logic [CNT_W-1:0]           new_cnt;
    logic [CNT_W-1:0]           last_cnt;
    logic                       in_fire;
    logic                       out_free;
    action_t                    act;
    entry_t                     rd;
    logic                       div_start;
    logic                       div_done [4];
    logic signed [SUM_W-1:0]    quo [4];

    assign act        = action_t'(cand.action);
    assign out_free   = !out_valid_reg || report.ready;
    assign cand.ready = (state_reg == S_IDLE) && out_free;
    assign in_fire    = cand.valid && cand.ready;

    assign cand_entry = '{dist_sq: cand.dist_sq, id: cand.neighbor_id, pos_x: cand.pos_x,
                          pos_z: cand.pos_z, dir_x: cand.dir_x, dir_z: cand.dir_z};

    // Capacity zero counts as one; anything above the built depth saturates.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(MAX_ENTRIES))
        begin
            cap_eff = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    // When full, the candidate must beat the last held entry. A capacity lowered
    // below the count also counts as full, and the count then stays.
    assign last_cnt = held_reg - 1'b1;
    assign full     = held_reg >= cap_eff;
    assign ins_ok   = !full || rb[last_cnt[IDX_W-1:0]];
    assign new_cnt  = full ? held_reg : held_reg + 1'b1;
    assign ins_go   = in_fire && (act == ACT_INSERT) && ins_ok;

    // The list is sorted, so the ranking bits rise once along the row; slots at
    // and beyond the new last place act as if the candidate ranks before them.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            assign eff_rb[gi] = rb[gi] || ((CNT_W'(gi) + 1'b1) >= new_cnt);
            if (gi == 0)
            begin : g_head
                assign ctrl[gi].take_cand = ins_go && eff_rb[gi];
                assign ctrl[gi].take_left = 1'b0;
                kns_cell u_cell (
                    .clk          (clk),
                    .cand         (cand_entry),
                    .left         (cand_entry),
                    .ctrl         (ctrl[gi]),
                    .entry        (cells[gi]),
                    .ranks_before (rb[gi])
                );
            end
            else
            begin : g_body
                assign ctrl[gi].take_cand = ins_go && eff_rb[gi] && !eff_rb[gi-1];
                assign ctrl[gi].take_left = ins_go && eff_rb[gi-1] &&
                                            (CNT_W'(gi) < new_cnt);
                kns_cell u_cell (
                    .clk          (clk),
                    .cand         (cand_entry),
                    .left         (cells[gi-1]),
                    .ctrl         (ctrl[gi]),
                    .entry        (cells[gi]),
                    .ranks_before (rb[gi])
                );
            end
        end
    endgenerate

    assign rd = cells[idx_reg];

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        cx_next        = cx_reg;
        cz_next        = cz_reg;
        dx_next        = dx_reg;
        dz_next        = dz_reg;
        out_valid_next = out_valid_reg && !report.ready;
        out_cnt_next   = out_cnt_reg;
        out_acc_next   = out_acc_reg;
        div_start      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = 1'b0;
                    out_cnt_next   = held_reg;
                    unique case (act)
                        ACT_CLEAR:
                        begin
                            held_next    = '0;
                            out_cnt_next = '0;
                        end
                        ACT_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                held_next    = new_cnt;
                                out_cnt_next = new_cnt;
                                out_acc_next = 1'b1;
                            end
                        end
                        ACT_FINALIZE:
                        begin
                            if (held_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                                idx_next       = '0;
                                for (int k = 0; k < 4; k++)
                                begin
                                    acc_next[k] = '0;
                                end
                                state_next = S_SUM;
                            end
                        end
                        ACT_UNUSED:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SUM:
            begin
                acc_next[0] = acc_reg[0] + SUM_W'(rd.pos_x);
                acc_next[1] = acc_reg[1] + SUM_W'(rd.pos_z);
                acc_next[2] = acc_reg[2] + SUM_W'(rd.dir_x);
                acc_next[3] = acc_reg[3] + SUM_W'(rd.dir_z);
                idx_next    = idx_reg + 1'b1;
                if ({1'b0, idx_reg} == last_cnt)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done[0] && div_done[1] && div_done[2] && div_done[3])
                begin
                    cx_next    = quo[0][POS_BITS-1:0];
                    cz_next    = quo[1][POS_BITS-1:0];
                    dx_next    = quo[2][DIR_BITS-1:0];
                    dz_next    = quo[3][DIR_BITS-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = held_reg;
                    out_acc_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    generate
        for (gi = 0; gi < 4; gi++)
        begin : g_div
            kns_div u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (div_start),
                .sum      (acc_next[gi]),
                .divisor  (held_reg),
                .done     (div_done[gi]),
                .quotient (quo[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CNT_W'(MAX_ENTRIES);
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            cx_reg        <= '0;
            cz_reg        <= '0;
            dx_reg        <= '0;
            dz_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            cx_reg        <= cx_next;
            cz_reg        <= cz_next;
            dx_reg        <= dx_next;
            dz_reg        <= dz_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        acc_reg     <= acc_next;
        out_cnt_reg <= out_cnt_next;
        out_acc_reg <= out_acc_next;
    end

    // The means are stored state, so the report reads them directly.
    assign report.valid       = out_valid_reg;
    assign report.entry_count = out_cnt_reg;
    assign report.accepted    = out_acc_reg;
    assign report.centroid_x  = cx_reg;
    assign report.centroid_z  = cz_reg;
    assign report.mean_dir_x  = dx_reg;
    assign report.mean_dir_z  = dz_reg;

endmodule
